// ===== src/sws_pkg.sv =====
// Package for the sliding window statistics block: widths, item types and state codes.
package sws_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int WINDOW_MAX_DEF = 16;
    localparam int CNT_W          = 5;
    localparam int SUM_W          = SAMPLE_WIDTH + CNT_W;
    localparam logic [CNT_W-1:0] WINDOW_LENGTH_RST = CNT_W'(16);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           clear;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] average;
        logic signed [SAMPLE_WIDTH-1:0] minimum;
        logic signed [SAMPLE_WIDTH-1:0] maximum;
        logic [CNT_W-1:0]               fill_count;
        logic                           window_full;
    } out_item_t;

    // Running statistics handed from one cell to the next.
    typedef struct packed {
        logic                           empty;
        logic signed [SUM_W-1:0]        sum;
        logic signed [SAMPLE_WIDTH-1:0] min_val;
        logic signed [SAMPLE_WIDTH-1:0] max_val;
    } partial_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DIV,
        S_OUT
    } state_t;

endpackage

// ===== src/sliding_window_statistics.sv =====
// Top level of the sliding window statistics block: ring control, cell chain and divider.
// An accepted item passes the launch register, the register of every cell in the chain, the
// bit-serial divider and the output register before its result appears on m_item.
// The block takes one item at a time: the next item is accepted only once the previous result
// has moved to the output register; the walk along the cell chain and the divider set the pace.
// Reset (aresetn, synchronous, active low) empties the window, zeroes every cell,
// and sets window_length to 16.
module sliding_window_statistics
    import sws_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_item
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    // Configuration register and the effective window length derived from it.
    // A length of zero acts as one, a length above the cell count acts as the cell count.
    logic [CNT_W-1:0] window_length_reg;
    logic [CNT_W-1:0] eff_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WINDOW_LENGTH_RST;
        end else if (cfg_we) begin
            window_length_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (window_length_reg == '0) begin
            eff_len = CNT_W'(1);
        end else if (32'(window_length_reg) > WINDOW_MAX) begin
            eff_len = CNT_W'(WINDOW_MAX);
        end else begin
            eff_len = window_length_reg;
        end
    end

    // Ring control. A push lands at the write position, which then wraps to zero once
    // it reaches the effective length; the fill count grows only while below it.
    logic             in_accept;
    logic             push;
    logic             wipe;
    logic [IDX_W-1:0] wpos_reg;
    logic [IDX_W-1:0] wpos_next;
    logic [CNT_W-1:0] held_reg;
    logic [CNT_W-1:0] held_next;

    assign in_accept = s_valid && s_ready;
    assign push      = in_accept && !s_item.clear;
    assign wipe      = in_accept && s_item.clear;

    always_comb begin
        wpos_next = wpos_reg;
        held_next = held_reg;
        if (wipe) begin
            wpos_next = '0;
            held_next = '0;
        end else if (push) begin
            if (32'(wpos_reg) + 1 >= 32'(eff_len)) begin
                wpos_next = '0;
            end else begin
                wpos_next = wpos_reg + 1'b1;
            end
            if (held_reg < eff_len) begin
                held_next = held_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg <= '0;
            held_reg <= '0;
        end else begin
            wpos_reg <= wpos_next;
            held_reg <= held_next;
        end
    end

    // The cell chain. In the cycle after the item is taken (so that the write has landed),
    // an empty statistics record enters the first cell and every cell whose index lies
    // below the fill count folds its sample in as the record passes.
    logic     launch_reg;
    logic     chain_valid [WINDOW_MAX+1];
    partial_t chain_part  [WINDOW_MAX+1];

    assign chain_valid[0]        = launch_reg;
    assign chain_part[0].empty   = 1'b1;
    assign chain_part[0].sum     = '0;
    assign chain_part[0].min_val = '0;
    assign chain_part[0].max_val = '0;

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        sws_cell #(
            .INDEX (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .wr_en     (push),
            .clear     (wipe),
            .wr_pos    (wpos_reg),
            .wr_data   (s_item.sample),
            .count     (held_reg),
            .valid_in  (chain_valid[i]),
            .part_in   (chain_part[i]),
            .valid_out (chain_valid[i+1]),
            .part_out  (chain_part[i+1])
        );
    end

    // Statistics captured at the end of the chain while the mean is divided out.
    logic                           stat_empty_reg;
    logic signed [SAMPLE_WIDTH-1:0] stat_min_reg;
    logic signed [SAMPLE_WIDTH-1:0] stat_max_reg;
    logic                           chain_done;
    logic                           div_start;
    logic                           div_done;
    logic signed [SUM_W-1:0]        div_quotient;
    logic signed [SAMPLE_WIDTH-1:0] avg_reg;

    assign chain_done = chain_valid[WINDOW_MAX];

    sws_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (chain_part[WINDOW_MAX].sum),
        .divisor  (held_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (div_start) begin
            stat_empty_reg <= chain_part[WINDOW_MAX].empty;
            stat_min_reg   <= chain_part[WINDOW_MAX].min_val;
            stat_max_reg   <= chain_part[WINDOW_MAX].max_val;
        end
        if (div_done) begin
            avg_reg <= div_quotient[SAMPLE_WIDTH-1:0];
        end
    end

    // Sequencer: take one item, walk the chain, divide, then hand the result to the
    // output register. The output register lets the next item in while a result waits.
    state_t    state_reg;
    state_t    state_next;
    logic      launch_next;
    logic      load_out;
    logic      m_valid_reg;
    logic      m_valid_next;
    out_item_t m_item_reg;

    always_comb begin
        state_next  = state_reg;
        launch_next = 1'b0;
        s_ready     = 1'b0;
        div_start   = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    launch_next = 1'b1;
                    state_next  = S_WALK;
                end
            end
            S_WALK: begin
                if (chain_done) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            launch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // An empty window reports zero for the mean, the minimum and the maximum.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_item_reg.average     <= stat_empty_reg ? '0 : avg_reg;
            m_item_reg.minimum     <= stat_empty_reg ? '0 : stat_min_reg;
            m_item_reg.maximum     <= stat_empty_reg ? '0 : stat_max_reg;
            m_item_reg.fill_count  <= held_reg;
            m_item_reg.window_full <= held_reg >= eff_len;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // The statistics record reaches the end of the chain only while the sequencer waits.
    a_chain_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_done |-> state_reg == S_WALK)
        else $error("chain result arrived outside the walk");

    // The divider finishes only while the sequencer waits for it.
    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    // A clear empties the window.
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        wipe |=> (held_reg == '0) && (wpos_reg == '0))
        else $error("clear did not empty the window");

    // The write position always names an existing cell.
    a_wpos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(wpos_reg) < WINDOW_MAX)
        else $error("write position beyond the last cell");

    // A result is loaded only into a free or draining output register.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

endmodule

// ===== src/sws_cell.sv =====
// One window cell: holds one sample and folds it into the passing statistics.
module sws_cell
    import sws_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic                           clear,
    input  logic [IDX_W-1:0]               wr_pos,
    input  logic signed [SAMPLE_WIDTH-1:0] wr_data,
    input  logic [CNT_W-1:0]               count,
    input  logic                           valid_in,
    input  partial_t                       part_in,
    output logic                           valid_out,
    output partial_t                       part_out
);

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           valid_reg;
    partial_t                       part_reg;
    partial_t                       part_next;
    logic                           take_sample;
    logic signed [SUM_W-1:0]        sample_ext;

    assign take_sample = 32'(count) > 32'(INDEX);
    assign sample_ext  = signed'({{CNT_W{sample_reg[SAMPLE_WIDTH-1]}}, sample_reg});

    always_comb begin
        part_next = part_in;
        if (take_sample) begin
            if (part_in.empty) begin
                part_next.empty   = 1'b0;
                part_next.sum     = sample_ext;
                part_next.min_val = sample_reg;
                part_next.max_val = sample_reg;
            end else begin
                part_next.sum = part_in.sum + sample_ext;
                if (sample_reg < part_in.min_val) begin
                    part_next.min_val = sample_reg;
                end
                if (sample_reg > part_in.max_val) begin
                    part_next.max_val = sample_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_in;
            if (clear) begin
                sample_reg <= '0;
            end else if (wr_en && (wr_pos == IDX_W'(INDEX))) begin
                sample_reg <= wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        part_reg <= part_next;
    end

    assign valid_out = valid_reg;
    assign part_out  = part_reg;

endmodule

// ===== src/sws_divider.sv =====
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
module sws_divider
    import sws_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic                neg_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    div_reg;
    logic [CNT_W:0]      shifted;
    logic                ge;
    logic [CNT_W:0]      diff;

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign ge      = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[SUM_W-1];
            quo_reg <= dividend[SUM_W-1] ? unsigned'(-dividend) : unsigned'(dividend);
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);

endmodule

// ===== sim/tb.sv =====
// Testbench for the sliding window statistics block: scoreboard class, drivers and checks.
`timescale 1ns / 1ps

import sws_pkg::*;

class window_scoreboard;
    logic signed [SAMPLE_WIDTH-1:0] ring [WINDOW_MAX_DEF];
    int unsigned                    wr_pos;
    int unsigned                    held;
    logic [CNT_W-1:0]               win_len;
    out_item_t                      expected_q [$];
    int                             errors;
    int                             n_items;
    int                             n_clears;
    int                             n_results;
    int                             n_full;

    function new();
        foreach (ring[i]) ring[i] = '0;
        wr_pos   = 0;
        held     = 0;
        win_len  = WINDOW_LENGTH_RST;
        errors   = 0;
        n_items  = 0;
        n_clears = 0;
        n_results = 0;
        n_full   = 0;
    endfunction

    function void set_length(logic [CNT_W-1:0] v);
        win_len = v;
    endfunction

    // A length of zero behaves as one, anything above the ring size as the ring size.
    function int unsigned active_length();
        if (win_len == 0) return 1;
        if (win_len > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
        return win_len;
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 30) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    // Updates the ring for one accepted item and queues the statistics it must produce.
    function void note_input(in_item_t it);
        int unsigned                    len;
        longint                         sum;
        logic signed [SAMPLE_WIDTH-1:0] lo;
        logic signed [SAMPLE_WIDTH-1:0] hi;
        out_item_t                      exp_stats;
        len = active_length();
        n_items++;
        if (it.clear) begin
            foreach (ring[i]) ring[i] = '0;
            wr_pos = 0;
            held   = 0;
            n_clears++;
        end else begin
            ring[wr_pos] = it.sample;
            wr_pos++;
            if (wr_pos >= len) wr_pos = 0;
            if (held < len) held++;
        end
        sum = 0;
        lo  = '0;
        hi  = '0;
        // Statistics cover entries 0 .. held-1, even after the length has shrunk.
        if (held > 0) begin
            lo = ring[0];
            hi = ring[0];
            for (int i = 0; i < held; i++) begin
                sum += ring[i];
                if (ring[i] < lo) lo = ring[i];
                if (ring[i] > hi) hi = ring[i];
            end
            sum = sum / longint'(held);
        end
        exp_stats.average     = SAMPLE_WIDTH'(sum);
        exp_stats.minimum     = lo;
        exp_stats.maximum     = hi;
        exp_stats.fill_count  = CNT_W'(held);
        exp_stats.window_full = (held >= len);
        expected_q.push_back(exp_stats);
    endfunction

    function void check_result(out_item_t got);
        out_item_t exp_stats;
        n_results++;
        if (got.window_full === 1'b1) n_full++;
        if (expected_q.size() == 0) begin
            report("result item arrived with no item waiting for it");
            return;
        end
        exp_stats = expected_q.pop_front();
        if (got.average !== exp_stats.average)
            report($sformatf("average got %0d expected %0d", got.average, exp_stats.average));
        if (got.minimum !== exp_stats.minimum)
            report($sformatf("minimum got %0d expected %0d", got.minimum, exp_stats.minimum));
        if (got.maximum !== exp_stats.maximum)
            report($sformatf("maximum got %0d expected %0d", got.maximum, exp_stats.maximum));
        if (got.fill_count !== exp_stats.fill_count)
            report($sformatf("fill_count got %0d expected %0d",
                             got.fill_count, exp_stats.fill_count));
        if (got.window_full !== exp_stats.window_full)
            report($sformatf("window_full got %0b expected %0b",
                             got.window_full, exp_stats.window_full));
    endfunction

    function void check_leftover();
        if (expected_q.size() != 0)
            report($sformatf("%0d result items never arrived", expected_q.size()));
    endfunction
endclass

module tb;
    import sws_pkg::*;

    // Longest stretch without any handshake before the run is declared hung. The slowest
    // correct stretch is the long receiver hold below plus one pass through the block,
    // so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int N_PHASES       = 14;
    localparam int PHASE_ITEMS    = 125;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    window_scoreboard sb;

    // When idle_on is set both sides insert random idle bursts. The long hold request is
    // raised by the stimulus process and cleared by the receiver once it has served it.
    bit idle_on;
    bit long_hold_req;
    int stall_cycles;
    int n_settings;

    sliding_window_statistics u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // All handshakes are observed at the rising edge. A result item is checked before the
    // input item of the same edge is noted, although the two can never belong together.
    // The same block runs the watchdog on cycles where nothing moves.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_item);
            if (s_valid && s_ready) sb.note_input(s_item);
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired after %0d cycles without a handshake",
                         stall_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // The receiver drives m_ready from its own process. A long hold is counted here in
    // cycles, so the sender keeps offering items while the block backs up.
    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
    end

    function automatic in_item_t make_item(bit clr, logic signed [SAMPLE_WIDTH-1:0] smp);
        in_item_t it;
        it.clear  = clr;
        it.sample = smp;
        return it;
    endfunction

    // Samples lean toward the extremes and small values, so sums cancel, saturate the
    // sample range and exercise truncation toward zero on both signs.
    function automatic in_item_t random_item();
        logic signed [SAMPLE_WIDTH-1:0] smp;
        case ($urandom_range(0, 9))
            0:       smp = 16'sh7FFF;
            1:       smp = 16'sh8000;
            2:       smp = $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
            3, 4:    smp = SAMPLE_WIDTH'(int'($urandom_range(0, 511)) - 256);
            default: smp = SAMPLE_WIDTH'($urandom_range(0, 65535));
        endcase
        return make_item($urandom_range(0, 24) == 0, smp);
    endfunction

    // Offers one item, possibly after an idle burst, and returns at the falling edge after
    // it was accepted with valid still high.
    task automatic send_item(input in_item_t it);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stops offering items and waits until every expected result has come back. It always
    // advances at least one edge, so valid is never lowered and raised in one step.
    task automatic wait_results_done();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.expected_q.size() != 0);
    endtask

    // The length register is only written while the block is idle with nothing pending.
    task automatic write_length(input logic [CNT_W-1:0] v);
        wait_results_done();
        repeat (4) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        sb.set_length(v);
        n_settings++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int phase_len [N_PHASES];
        phase_len     = '{16, 1, 16, 0, 31, 2, 17, 8, 3, 16, 5, 12, 15, 16};
        sb            = new();
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_item       <= '0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        stall_cycles  = 0;
        n_settings    = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. A clear on an empty window must report zeros, and its sample
        // field is ignored.
        send_item(make_item(1'b1, 16'sh7FFF));
        // Both extremes, then a negative mean that truncates toward zero (-5 / 4 -> -1).
        send_item(make_item(1'b0, 16'sh7FFF));
        send_item(make_item(1'b0, 16'sh8000));
        send_item(make_item(1'b0, -16'sd1));
        send_item(make_item(1'b0, -16'sd3));
        // Length zero acts as one and is written while four samples are held: the count
        // stays at four; the next sample still lands at position four, then the write position wraps to the start.
        write_length(0);
        send_item(make_item(1'b0, 16'sd5));
        send_item(make_item(1'b0, 16'sd6));
        send_item(make_item(1'b1, 16'sh8000));
        send_item(make_item(1'b0, 16'sd100));
        send_item(make_item(1'b0, 16'sd200));
        // A length above the ring size acts as the full ring; the sum outgrows a sample.
        write_length(31);
        repeat (3) send_item(make_item(1'b0, 16'sh7FFF));
        write_length(2);
        send_item(make_item(1'b1, 16'sd0));
        repeat (3) send_item(make_item(1'b0, 16'sh8000));
        send_item(make_item(1'b0, 16'sd1));
        write_length(1);
        send_item(make_item(1'b0, 16'sd7));

        // Random part: one window setting per phase, most phases starting from a clear and
        // some keeping whatever the previous length left behind.
        for (int p = 0; p < N_PHASES; p++) begin
            write_length(p < 3 ? CNT_W'(phase_len[p]) :
                         ($urandom_range(0, 3) == 0 ? CNT_W'($urandom_range(0, 31))
                                                    : CNT_W'(phase_len[p])));
            if ($urandom_range(0, 3) != 0) send_item(make_item(1'b1, 16'sd0));
            // The final stretch of the run has no idling on either side.
            if (p >= N_PHASES - 2) idle_on = 1'b0;
            // Back up the block behind a long receiver hold while items keep coming.
            if (p == 2) long_hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 9 && k == 60) wait_results_done();
                send_item(random_item());
            end
        end

        wait_results_done();
        repeat (50) @(negedge aclk);
        sb.check_leftover();

        $display("Covered %0d items including %0d clears, %0d results over %0d lengths.",
                 sb.n_items, sb.n_clears, sb.n_results, n_settings);
        $display("Results with the window full: %0d; mismatches counted: %0d.",
                 sb.n_full, sb.errors);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
